### rtl/banked_register_file_defines.svh
// assertion macros used by the banked register file top module
`ifndef BANKED_REGISTER_FILE_DEFINES_SVH
`define BANKED_REGISTER_FILE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/brf_pkg.sv
// shared constants and types of the banked register file
package brf_pkg;

  localparam int unsigned StoreWords = 37;
  localparam int unsigned SlotW      = $clog2(StoreWords);
  localparam int unsigned WordW      = 32;
  localparam int unsigned ModeW      = 5;
  localparam int unsigned RegW       = 4;
  localparam int unsigned ActW       = 3;

  // action codes
  localparam logic [ActW-1:0] ACT_READ_REG     = 3'd0;
  localparam logic [ActW-1:0] ACT_WRITE_REG    = 3'd1;
  localparam logic [ActW-1:0] ACT_READ_STATUS  = 3'd2;
  localparam logic [ActW-1:0] ACT_WRITE_STATUS = 3'd3;
  localparam logic [ActW-1:0] ACT_READ_SAVED   = 3'd4;
  localparam logic [ActW-1:0] ACT_WRITE_SAVED  = 3'd5;

  // processor mode codes
  localparam logic [ModeW-1:0] MODE_USR = 5'b10000;
  localparam logic [ModeW-1:0] MODE_FIQ = 5'b10001;
  localparam logic [ModeW-1:0] MODE_IRQ = 5'b10010;
  localparam logic [ModeW-1:0] MODE_SVC = 5'b10011;
  localparam logic [ModeW-1:0] MODE_ABT = 5'b10111;
  localparam logic [ModeW-1:0] MODE_UND = 5'b11011;
  localparam logic [ModeW-1:0] MODE_SYS = 5'b11111;

  // store layout
  localparam logic [SlotW-1:0] SLOT_STATUS    = 6'd31;
  localparam logic [SlotW-1:0] SLOT_SAVED_SVC = 6'd32;
  localparam logic [SlotW-1:0] SLOT_SAVED_ABT = 6'd33;
  localparam logic [SlotW-1:0] SLOT_SAVED_UND = 6'd34;
  localparam logic [SlotW-1:0] SLOT_SAVED_IRQ = 6'd35;
  localparam logic [SlotW-1:0] SLOT_SAVED_FIQ = 6'd36;

  // bank offsets added to the visible register number
  localparam logic [SlotW-1:0] OFS_FIQ = 6'd16;
  localparam logic [SlotW-1:0] OFS_IRQ = 6'd9;
  localparam logic [SlotW-1:0] OFS_SVC = 6'd3;
  localparam logic [SlotW-1:0] OFS_ABT = 6'd5;
  localparam logic [SlotW-1:0] OFS_UND = 6'd7;

  // one decoded store access
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             status_wr;
    logic [SlotW-1:0] slot;
  } brf_access_t;

endpackage

### rtl/brf_decode.sv
// maps an access to a store slot and read or write strobes
module brf_decode
  import brf_pkg::*;
(
  input  logic [ActW-1:0]  action,
  input  logic [RegW-1:0]  reg_index,
  input  logic [ModeW-1:0] access_mode,
  output brf_access_t      acc
);

  logic [SlotW-1:0] reg_base;
  logic [SlotW-1:0] reg_slot;
  logic [SlotW-1:0] saved_slot;
  logic             saved_ok;

  assign reg_base = {{(SlotW-RegW){1'b0}}, reg_index};

  // banked slot of a visible register
  always_comb begin
    reg_slot = reg_base;
    if (reg_index >= 4'd8 && reg_index <= 4'd12) begin
      if (access_mode == MODE_FIQ) reg_slot = reg_base + OFS_FIQ;
    end else if (reg_index == 4'd13 || reg_index == 4'd14) begin
      unique case (access_mode)
        MODE_FIQ: reg_slot = reg_base + OFS_FIQ;
        MODE_IRQ: reg_slot = reg_base + OFS_IRQ;
        MODE_SVC: reg_slot = reg_base + OFS_SVC;
        MODE_ABT: reg_slot = reg_base + OFS_ABT;
        MODE_UND: reg_slot = reg_base + OFS_UND;
        default:  reg_slot = reg_base;
      endcase
    end
  end

  // saved status slot, none for user, system and unlisted modes
  always_comb begin
    saved_ok   = 1'b1;
    saved_slot = SLOT_SAVED_SVC;
    unique case (access_mode)
      MODE_FIQ: saved_slot = SLOT_SAVED_FIQ;
      MODE_IRQ: saved_slot = SLOT_SAVED_IRQ;
      MODE_SVC: saved_slot = SLOT_SAVED_SVC;
      MODE_ABT: saved_slot = SLOT_SAVED_ABT;
      MODE_UND: saved_slot = SLOT_SAVED_UND;
      default:  saved_ok   = 1'b0;
    endcase
  end

  // action decode
  always_comb begin
    acc = '0;
    unique case (action)
      ACT_READ_REG: begin
        acc.rd   = 1'b1;
        acc.slot = reg_slot;
      end
      ACT_WRITE_REG: begin
        acc.wr   = 1'b1;
        acc.slot = reg_slot;
      end
      ACT_READ_STATUS: begin
        acc.rd   = 1'b1;
        acc.slot = SLOT_STATUS;
      end
      ACT_WRITE_STATUS: begin
        acc.wr        = 1'b1;
        acc.status_wr = 1'b1;
        acc.slot      = SLOT_STATUS;
      end
      ACT_READ_SAVED: begin
        acc.rd   = saved_ok;
        acc.slot = saved_slot;
      end
      ACT_WRITE_SAVED: begin
        acc.wr   = saved_ok;
        acc.slot = saved_slot;
      end
      default: acc = '0;
    endcase
  end

endmodule

### rtl/brf_store.sv
// 37-word store with per-word valid bits and registered read
module brf_store
  import brf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [SlotW-1:0] slot,
  input  logic [WordW-1:0] wdata,
  output logic [WordW-1:0] rdata
);

  logic [WordW-1:0]      mem [0:StoreWords-1];
  logic [StoreWords-1:0] written;

  // word array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) mem[slot] <= wdata;
  end

  // valid bits, a never-written word reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[slot] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) rdata <= written[slot] ? mem[slot] : '0;
  end

endmodule

### rtl/banked_register_file.sv
// Banked register file: 37 words (16 visible registers banked by mode, one status word,
// five saved status words). One access is taken per beat; an item can enter every cycle
// while in_stall is low. An accepted access does the synchronous store read into the read
// stage, and the output register then loads the result whenever out_stall lets it advance.
// Reads of words not written since reset return zero.
// in_stall rises only while a result sits in the output register under out_stall and the
// store read stage is also occupied. current_mode tracks the status word after each beat.
module banked_register_file
  import brf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ActW-1:0]  action,
  input  logic [RegW-1:0]  reg_index,
  input  logic [ModeW-1:0] access_mode,
  input  logic [WordW-1:0] write_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] read_data,
  output logic [ModeW-1:0] current_mode,
  output logic             mode_has_saved,
  output logic             privileged
);

`include "banked_register_file_defines.svh"

  brf_access_t      acc;
  logic             accept;
  logic             advance;
  logic             s1_valid;
  logic             s1_rd;
  logic [WordW-1:0] store_q;
  logic [ModeW-1:0] mode;

  brf_decode u_decode (
    .action      (action),
    .reg_index   (reg_index),
    .access_mode (access_mode),
    .acc         (acc)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  brf_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr_en (accept && acc.wr),
    .rd_en (accept && acc.rd),
    .slot  (acc.slot),
    .wdata (write_value),
    .rdata (store_q)
  );

  // shadow of the status mode bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (accept && acc.status_wr) begin
      mode <= write_value[ModeW-1:0];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_rd <= acc.rd;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      read_data    <= s1_rd ? store_q : '0;
      current_mode <= mode;
    end
  end

  assign mode_has_saved = !(current_mode == MODE_USR || current_mode == MODE_SYS);
  assign privileged     = current_mode != MODE_USR;

  // checks
  `BRF_ASSERT_NOW(a_stall_needs_s1, in_stall, s1_valid, "input stalled with empty read stage")
  `BRF_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid, "accepted beat missing in read stage")
  `BRF_ASSERT_NEXT(a_s1_reaches_out, s1_valid && advance, out_valid, "read stage beat lost")
  `BRF_ASSERT_NOW(a_mode_flags, out_valid && !privileged, !mode_has_saved,
                  "user mode reported with saved status")

endmodule

### verif/testbench.sv
// self-checking testbench for the banked register file with a scoreboard class
import brf_pkg::*;

// codes of the action field that the block treats as no operation
localparam logic [ActW-1:0] ACT_UNUSED_LO = 3'd6;
localparam logic [ActW-1:0] ACT_UNUSED_HI = 3'd7;

typedef struct packed {
  logic [WordW-1:0] data;
  logic [ModeW-1:0] mode;
  logic             has_saved;
  logic             priv;
} regfile_result_t;

class regfile_scoreboard;
  logic [WordW-1:0] shadow_store [StoreWords];
  regfile_result_t  expected_q [$];
  int               errors;
  int               checked;

  function new();
    foreach (shadow_store[i]) shadow_store[i] = '0;
    errors  = 0;
    checked = 0;
  endfunction

  // store slot of a visible register under the given mode
  function int bank_slot(logic [RegW-1:0] r, logic [ModeW-1:0] m);
    if (r >= 8 && r <= 12) begin
      return (m == MODE_FIQ) ? int'(r) + int'(OFS_FIQ) : int'(r);
    end
    if (r == 13 || r == 14) begin
      case (m)
        MODE_FIQ: return int'(r) + int'(OFS_FIQ);
        MODE_IRQ: return int'(r) + int'(OFS_IRQ);
        MODE_SVC: return int'(r) + int'(OFS_SVC);
        MODE_ABT: return int'(r) + int'(OFS_ABT);
        MODE_UND: return int'(r) + int'(OFS_UND);
        default:  return int'(r);
      endcase
    end
    return int'(r);
  endfunction

  // saved status slot of a mode; returns 0 when the mode has none
  function bit saved_slot(logic [ModeW-1:0] m, output int slot);
    slot = 0;
    case (m)
      MODE_FIQ: slot = int'(SLOT_SAVED_FIQ);
      MODE_IRQ: slot = int'(SLOT_SAVED_IRQ);
      MODE_SVC: slot = int'(SLOT_SAVED_SVC);
      MODE_ABT: slot = int'(SLOT_SAVED_ABT);
      MODE_UND: slot = int'(SLOT_SAVED_UND);
      default:  return 0;
    endcase
    return 1;
  endfunction

  // apply one accepted access and queue the result it should produce
  function void note_input(logic [ActW-1:0] act, logic [RegW-1:0] r,
                           logic [ModeW-1:0] m, logic [WordW-1:0] v);
    regfile_result_t e;
    int              slot;
    logic [ModeW-1:0] cur;
    e.data = '0;
    case (act)
      ACT_READ_REG:     e.data = shadow_store[bank_slot(r, m)];
      ACT_WRITE_REG:    shadow_store[bank_slot(r, m)] = v;
      ACT_READ_STATUS:  e.data = shadow_store[SLOT_STATUS];
      ACT_WRITE_STATUS: shadow_store[SLOT_STATUS] = v;
      ACT_READ_SAVED:   if (saved_slot(m, slot)) e.data = shadow_store[slot];
      ACT_WRITE_SAVED:  if (saved_slot(m, slot)) shadow_store[slot] = v;
      default: ;
    endcase
    cur         = shadow_store[SLOT_STATUS][ModeW-1:0];
    e.mode      = cur;
    e.has_saved = !(cur == MODE_USR || cur == MODE_SYS);
    e.priv      = (cur != MODE_USR);
    expected_q.push_back(e);
  endfunction

  // compare one result beat with the oldest expectation
  function void check_result(logic [WordW-1:0] d, logic [ModeW-1:0] m,
                             logic hs, logic pv);
    regfile_result_t e;
    if (expected_q.size() == 0) begin
      $error("result beat arrived with nothing expected");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (d !== e.data) begin
      $error("read_data: expected %h, got %h", e.data, d);
      errors++;
    end
    if (m !== e.mode) begin
      $error("current_mode: expected %h, got %h", e.mode, m);
      errors++;
    end
    if (hs !== e.has_saved) begin
      $error("mode_has_saved: expected %b, got %b", e.has_saved, hs);
      errors++;
    end
    if (pv !== e.priv) begin
      $error("privileged: expected %b, got %b", e.priv, pv);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  localparam logic [ModeW-1:0] BANKED_MODES [5] =
    '{MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND};
  localparam logic [ModeW-1:0] NAMED_MODES [7] =
    '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
  localparam int RandomBeats = 2000;
  localparam int HoldCycles  = 150;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ActW-1:0]  action = '0;
  logic [RegW-1:0]  reg_index = '0;
  logic [ModeW-1:0] access_mode = '0;
  logic [WordW-1:0] write_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WordW-1:0] read_data;
  logic [ModeW-1:0] current_mode;
  logic             mode_has_saved;
  logic             privileged;

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int accepted = 0;

  regfile_scoreboard sb = new();

  banked_register_file dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .reg_index(reg_index),
    .access_mode(access_mode), .write_value(write_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .current_mode(current_mode),
    .mode_has_saved(mode_has_saved), .privileged(privileged)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // offer one access beat and wait until it is taken
  task automatic send_beat(logic [ActW-1:0] act, logic [RegW-1:0] r,
                           logic [ModeW-1:0] m, logic [WordW-1:0] v);
    int gap;
    if (!quiet && !hold_req && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    reg_index   <= r;
    access_mode <= m;
    write_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, r, m, v);
    accepted++;
  endtask

  // mostly named modes, sometimes any code
  function automatic logic [ModeW-1:0] pick_mode();
    if ($urandom_range(0, 4) == 0) return ModeW'($urandom_range(0, 31));
    return NAMED_MODES[$urandom_range(0, 6)];
  endfunction

  task automatic send_random();
    logic [ActW-1:0]  act;
    logic [WordW-1:0] v;
    if ($urandom_range(0, 29) == 0) act = ActW'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    else act = ActW'($urandom_range(ACT_WRITE_SAVED, ACT_READ_REG));
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    // status writes mostly carry a meaningful mode in the low bits
    if (act == ACT_WRITE_STATUS && $urandom_range(0, 3) != 0) v[ModeW-1:0] = pick_mode();
    send_beat(act, RegW'($urandom_range(0, 15)), pick_mode(), v);
  endtask

  // receiver stall pattern, with one long hold on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(read_data, current_mode, mode_has_saved, privileged);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, status extremes, banking corners
    send_beat(ACT_READ_REG, 4'd0, MODE_USR, '0);
    send_beat(ACT_WRITE_STATUS, 4'd0, MODE_USR, 32'hffff_ffff);
    send_beat(ACT_READ_STATUS, 4'd0, MODE_USR, '0);
    send_beat(ACT_WRITE_REG, 4'd15, MODE_FIQ, 32'hffff_ffff);
    send_beat(ACT_READ_REG, 4'd15, MODE_USR, '0);
    send_beat(ACT_WRITE_REG, 4'd8, MODE_FIQ, 32'ha5a5_a5a5);
    send_beat(ACT_READ_REG, 4'd8, MODE_USR, '0);
    send_beat(ACT_READ_REG, 4'd8, MODE_FIQ, '0);
    foreach (BANKED_MODES[k])
      send_beat(ACT_WRITE_REG, 4'd13, BANKED_MODES[k], 32'h1300_0000 | k);
    foreach (BANKED_MODES[k])
      send_beat(ACT_READ_REG, 4'd13, BANKED_MODES[k], '0);
    // unlisted mode code falls back to the base bank
    send_beat(ACT_READ_REG, 4'd13, 5'd0, '0);
    send_beat(ACT_WRITE_SAVED, 4'd0, MODE_SVC, 32'h8000_0001);
    send_beat(ACT_READ_SAVED, 4'd0, MODE_SVC, '0);
    // saved status without a bank: write dropped, read gives zero
    send_beat(ACT_WRITE_SAVED, 4'd0, MODE_USR, 32'hffff_ffff);
    send_beat(ACT_READ_SAVED, 4'd0, MODE_USR, '0);
    send_beat(ACT_READ_SAVED, 4'd0, 5'd0, '0);
    send_beat(ACT_UNUSED_LO, 4'd15, MODE_FIQ, 32'hffff_ffff);
    send_beat(ACT_UNUSED_HI, 4'd14, MODE_SYS, 32'hffff_ffff);
    send_beat(ACT_WRITE_STATUS, 4'd0, MODE_USR, 32'h0000_0010);
    send_beat(ACT_WRITE_STATUS, 4'd0, MODE_USR, 32'h0000_0000);

    // random traffic; long output hold early, no idling at the tail
    for (int i = 0; i < RandomBeats; i++) begin
      if (i == 600) hold_req = 1'b1;
      if (i == RandomBeats - 300) quiet = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;

    // drain outstanding results, then allow for pipeline latency
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d access beats over all actions and mode banks, %0d results checked",
             accepted, sb.checked);
    $display("including a %0d cycle output hold that backed up the input", HoldCycles);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
